[src/wts_pkg.sv]
// ----------------------------------------------------------------------------
// wts_pkg: shared types and constants of the wavetable synth
// Action codes, voice register map, the controller command bundle,
// the volume log table and the step schedule of one voice.
// ----------------------------------------------------------------------------
package wts_pkg;

	localparam int MEM_BYTES  = 8192;
	localparam int ADDR_W     = 13;
	localparam int VOICES_DEF = 16;
	localparam int VOICE_W    = 4;
	localparam int STEP_W     = 5;

	// upper address bits of the voice register window
	localparam logic [4:0] REG_PAGE = 5'h1f;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_READ  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// byte offsets inside one voice's 16-byte register block
	localparam logic [3:0] REG_MOD    = 4'd0;
	localparam logic [3:0] REG_VOL    = 4'd1;
	localparam logic [3:0] REG_PAN    = 4'd2;
	localparam logic [3:0] REG_WAVE   = 4'd3;
	localparam logic [3:0] REG_END    = 4'd4;
	localparam logic [3:0] REG_LOOP   = 4'd5;
	localparam logic [3:0] REG_STEP0  = 4'd6;
	localparam logic [3:0] REG_STEP1  = 4'd7;
	localparam logic [3:0] REG_ACC0   = 4'd8;
	localparam logic [3:0] REG_ACC1   = 4'd9;
	localparam logic [3:0] REG_FREQ0  = 4'd10;
	localparam logic [3:0] REG_FREQ1  = 4'd11;
	localparam logic [3:0] REG_FREQ2  = 4'd12;
	localparam logic [3:0] REG_PHASE0 = 4'd13;
	localparam logic [3:0] REG_PHASE1 = 4'd14;
	localparam logic [3:0] REG_PHASE2 = 4'd15;

	// schedule of one voice, in controller steps
	localparam logic [STEP_W-1:0] ST_RD_LAST = 5'd15;
	localparam logic [STEP_W-1:0] ST_CALC    = 5'd17;
	localparam logic [STEP_W-1:0] ST_WAVE    = 5'd18;
	localparam logic [STEP_W-1:0] ST_SAMPLE  = 5'd19;
	localparam logic [STEP_W-1:0] ST_PAN     = 5'd20;
	localparam logic [STEP_W-1:0] ST_ACCUM   = 5'd21;
	localparam logic [STEP_W-1:0] ST_WR_WAVE = 5'd19;
	localparam logic [STEP_W-1:0] ST_WR_ACC0 = 5'd20;
	localparam logic [STEP_W-1:0] ST_WR_ACC1 = 5'd21;
	localparam logic [STEP_W-1:0] ST_WR_PH0  = 5'd22;
	localparam logic [STEP_W-1:0] ST_WR_PH1  = 5'd23;
	localparam logic [STEP_W-1:0] ST_WR_PH2  = 5'd24;
	localparam logic [STEP_W-1:0] ST_LAST    = 5'd24;

	localparam logic [4:0] SLOW_LAST = 5'h1f;

	typedef struct packed {
		logic               latch;
		logic               start_tick;
		logic               host_rd;
		logic               host_wr;
		logic               host_cap;
		logic               reg_rd;
		logic               reg_wr;
		logic [3:0]         reg_idx;
		logic               calc;
		logic               wave_rd;
		logic               sample;
		logic               pan_mul;
		logic               accum;
		logic [VOICE_W-1:0] voice;
	} cmd_t;

	localparam logic [7:0] LOG_VOL [64] = '{
		8'd0,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
		8'd2,   8'd2,   8'd2,   8'd2,   8'd3,   8'd3,   8'd3,   8'd3,
		8'd4,   8'd4,   8'd5,   8'd5,   8'd6,   8'd6,   8'd7,   8'd7,
		8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd13,  8'd14,  8'd15,
		8'd17,  8'd18,  8'd20,  8'd22,  8'd24,  8'd26,  8'd29,  8'd31,
		8'd34,  8'd37,  8'd41,  8'd45,  8'd49,  8'd53,  8'd58,  8'd63,
		8'd69,  8'd75,  8'd82,  8'd90,  8'd98,  8'd107, 8'd116, 8'd127,
		8'd139, 8'd151, 8'd165, 8'd180, 8'd196, 8'd214, 8'd233, 8'd255
	};

endpackage

[src/wts_in_if.sv]
// ----------------------------------------------------------------------------
// wts_in_if: request channel of the wavetable synth
// Valid/ready handshake carrying action, byte address and write data.
// ----------------------------------------------------------------------------
interface wts_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [12:0] address;
	logic [7:0]  write_data;

	modport source (output valid, action, address, write_data, input ready);
	modport sink   (input valid, action, address, write_data, output ready);
endinterface

[src/wts_out_if.sv]
// ----------------------------------------------------------------------------
// wts_out_if: result channel of the wavetable synth
// Valid/ready handshake carrying read byte and the stereo sample pair.
// ----------------------------------------------------------------------------
interface wts_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         read_data;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;

	modport source (output valid, read_data, left_sample, right_sample, input ready);
	modport sink   (input valid, read_data, left_sample, right_sample, output ready);
endinterface

[src/wavetable_synth_chip.sv]
// ----------------------------------------------------------------------------
// wavetable_synth_chip: 16-voice wavetable sound chip
// Byte write/read into an 8 KiB memory with voice registers at the top,
// and sample ticks that render one stereo mix of all voices.
//
//   channel   direction   payload
//   in_ch     sink        action, address, write_data
//   out_ch    source      read_data, left_sample, right_sample
//
// Every voice register byte, the wave byte and the write-back go one byte a
// cycle through the single memory port.
// One request is worked at a time; the result is held until out_ch takes it.
// Reset clears the voice registers (through per-byte valid bits), the noise
// state, previous outputs and the tick counter; wave bytes are not cleared.
// ----------------------------------------------------------------------------
module wavetable_synth_chip #(
	parameter int VOICES = wts_pkg::VOICES_DEF
) (
	input logic  clk,
	input logic  arst_n,
	wts_in_if.sink    in_ch,
	wts_out_if.source out_ch
);
	import wts_pkg::*;

	cmd_t cmd;

	wts_ctrl #(.VOICES(VOICES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.in_action (in_ch.action),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	wts_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.address      (in_ch.address),
		.write_data   (in_ch.write_data),
		.read_data    (out_ch.read_data),
		.left_sample  (out_ch.left_sample),
		.right_sample (out_ch.right_sample)
	);
endmodule

[src/wts_ram.sv]
// ----------------------------------------------------------------------------
// wts_ram: generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module wts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write or read one word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

[src/wts_ctrl.sv]
// ----------------------------------------------------------------------------
// wts_ctrl: sequencer of the wavetable synth
// Accepts requests, steps through host accesses and the per-voice schedule,
// and presents the result.
// ----------------------------------------------------------------------------
module wts_ctrl #(
	parameter int VOICES = wts_pkg::VOICES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_action,
	output logic                out_valid,
	input  logic                out_ready,
	output wts_pkg::cmd_t       cmd
);
	import wts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_HOST,
		S_HWAIT,
		S_TICK,
		S_OUT
	} state_t;

	localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [VOICE_W-1:0]  voice_q;
	logic                wr_q;

	// hold state, step and voice counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			voice_q <= '0;
			wr_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						step_q  <= '0;
						voice_q <= '0;
						unique case (in_action)
							ACT_WRITE: begin
								wr_q    <= 1'b1;
								state_q <= S_HOST;
							end
							ACT_READ: begin
								wr_q    <= 1'b0;
								state_q <= S_HOST;
							end
							ACT_TICK: state_q <= S_TICK;
							default:  state_q <= S_OUT;
						endcase
					end
				end
				S_HOST: state_q <= wr_q ? S_OUT : S_HWAIT;
				S_HWAIT: state_q <= S_OUT;
				S_TICK: begin
					if (step_q == ST_LAST) begin
						step_q <= '0;
						if (voice_q == LAST_VOICE) begin
							state_q <= S_OUT;
						end else begin
							voice_q <= voice_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	// decode datapath commands from state and step
	always_comb begin
		cmd       = '0;
		cmd.voice = voice_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch      = in_valid;
				cmd.start_tick = in_valid && (in_action == ACT_TICK);
			end
			S_HOST: begin
				cmd.host_rd = !wr_q;
				cmd.host_wr = wr_q;
			end
			S_HWAIT: cmd.host_cap = 1'b1;
			S_TICK: begin
				cmd.reg_rd  = (step_q <= ST_RD_LAST);
				cmd.reg_idx = step_q[3:0];
				cmd.calc    = (step_q == ST_CALC);
				cmd.wave_rd = (step_q == ST_WAVE);
				cmd.sample  = (step_q == ST_SAMPLE);
				cmd.pan_mul = (step_q == ST_PAN);
				cmd.accum   = (step_q == ST_ACCUM);
				case (step_q)
					ST_WR_WAVE: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_WAVE;
					end
					ST_WR_ACC0: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_ACC0;
					end
					ST_WR_ACC1: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_ACC1;
					end
					ST_WR_PH0: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_PHASE0;
					end
					ST_WR_PH1: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_PHASE1;
					end
					ST_WR_PH2: begin
						cmd.reg_wr  = 1'b1;
						cmd.reg_idx = REG_PHASE2;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end
endmodule

[src/wts_dp.sv]
// ----------------------------------------------------------------------------
// wts_dp: datapath of the wavetable synth
// Byte memory with register-window valid bits, voice register latches,
// modulation, phase and slow-step arithmetic, noise source and stereo mix.
// ----------------------------------------------------------------------------
module wts_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  wts_pkg::cmd_t      cmd,
	input  logic [12:0]        address,
	input  logic [7:0]         write_data,
	output logic [7:0]         read_data,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample
);
	import wts_pkg::*;

	// memory port
	logic              mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [7:0]        mem_wdata;
	logic [7:0]        ram_rdata;
	logic [7:0]        mem_rd;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic              reg_rd_s1;
	logic [3:0]        reg_idx_s1;
	logic [255:0]      valid_q;

	// latched request
	logic [ADDR_W-1:0] addr_q;
	logic [7:0]        wdata_q;
	logic [7:0]        read_data_q;

	// voice registers
	logic [7:0]  mod_q, vol_q, pan_q, wave_q, end_q, loop_q;
	logic [15:0] step_q, acc_q;
	logic [19:0] freq_q;
	logic [20:0] phase_q;

	// calc results
	logic [7:0]  level_q;
	logic [4:0]  pm_q;
	logic [20:0] phase_new_q;
	logic        toggle_q;
	logic [15:0] acc_new_q;
	logic [7:0]  wave_new_q;

	// voice state and mix
	logic [7:0]         noise_hold_q [16];
	logic [14:0]        shifter_q;
	logic signed [15:0] prior_q, second_q;
	logic [4:0]         slow_q;
	logic signed [16:0] o_q;
	logic signed [21:0] prod_l_q, prod_r_q;
	logic signed [17:0] sum_l_q, sum_r_q;

	// calc combinational terms
	logic [2:0]         m1, m2;
	logic signed [17:0] lvl, t1, t2;
	logic [20:0]        s1, s2, pm;
	logic [20:0]        phase_new;
	logic [16:0]        acc_sum;
	logic [7:0]         wave_next;
	logic [7:0]         sample_data;
	logic signed [16:0] o_next;

	wts_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (ram_rdata)
	);

	// select memory address and write data
	always_comb begin
		mem_we    = cmd.host_wr || cmd.reg_wr;
		mem_addr  = addr_q;
		mem_wdata = wdata_q;
		if (cmd.reg_rd || cmd.reg_wr) begin
			mem_addr = {REG_PAGE, cmd.voice, cmd.reg_idx};
		end else if (cmd.wave_rd) begin
			mem_addr = {wave_q, pm_q};
		end
		if (cmd.reg_wr) begin
			case (cmd.reg_idx)
				REG_WAVE:   mem_wdata = wave_new_q;
				REG_ACC0:   mem_wdata = acc_new_q[7:0];
				REG_ACC1:   mem_wdata = acc_new_q[15:8];
				REG_PHASE0: mem_wdata = phase_new_q[7:0];
				REG_PHASE1: mem_wdata = phase_new_q[15:8];
				default:    mem_wdata = {3'd0, phase_new_q[20:16]};
			endcase
		end
	end

	// unwritten register bytes read as zero
	assign mem_rd = ((rd_addr_s1[12:8] == REG_PAGE) && !valid_q[rd_addr_s1[7:0]])
		? 8'd0 : ram_rdata;

	// track register bytes that have been written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			reg_rd_s1 <= 1'b0;
		end else begin
			reg_rd_s1 <= cmd.reg_rd;
			if (mem_we && (mem_addr[12:8] == REG_PAGE)) begin
				valid_q[mem_addr[7:0]] <= 1'b1;
			end
		end
	end

	// hold read address and register index for the data return
	always_ff @(posedge clk) begin
		rd_addr_s1 <= mem_addr;
		reg_idx_s1 <= cmd.reg_idx;
	end

	// latch request and capture voice register bytes
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			addr_q  <= address;
			wdata_q <= write_data;
		end
		if (reg_rd_s1) begin
			case (reg_idx_s1)
				REG_MOD:    mod_q  <= mem_rd;
				REG_VOL:    vol_q  <= mem_rd;
				REG_PAN:    pan_q  <= mem_rd;
				REG_WAVE:   wave_q <= mem_rd;
				REG_END:    end_q  <= mem_rd;
				REG_LOOP:   loop_q <= mem_rd;
				REG_STEP0:  step_q[7:0]   <= mem_rd;
				REG_STEP1:  step_q[15:8]  <= mem_rd;
				REG_ACC0:   acc_q[7:0]    <= mem_rd;
				REG_ACC1:   acc_q[15:8]   <= mem_rd;
				REG_FREQ0:  freq_q[7:0]   <= mem_rd;
				REG_FREQ1:  freq_q[15:8]  <= mem_rd;
				REG_FREQ2:  freq_q[19:16] <= mem_rd[3:0];
				REG_PHASE0: phase_q[7:0]  <= mem_rd;
				REG_PHASE1: phase_q[15:8] <= mem_rd;
				default:    phase_q[20:16] <= mem_rd[4:0];
			endcase
		end
	end

	// modulation, phase advance and slow step
	always_comb begin
		m1  = mod_q[2:0];
		m2  = mod_q[6:4];
		t1  = 18'(prior_q) >>> (3'd7 - m1);
		t2  = 18'(second_q) >>> (3'd7 - m2);
		lvl = $signed({10'd0, LOG_VOL[vol_q[5:0]]});
		if ((m1 != 3'd0) && mod_q[3]) begin
			lvl = lvl + t1;
		end
		if ((m2 != 3'd0) && mod_q[7]) begin
			lvl = lvl + t2;
		end
		s1 = ((m1 != 3'd0) && !mod_q[3]) ? (21'(prior_q) << m1) : 21'd0;
		s2 = ((m2 != 3'd0) && !mod_q[7]) ? (21'(second_q) << m2) : 21'd0;
		pm = phase_q + s1 + s2;
		phase_new = phase_q + {1'b0, freq_q};
		acc_sum   = {1'b0, acc_q} + {1'b0, step_q};
		wave_next = (wave_q == end_q) ? loop_q : wave_q + 8'd1;
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			if (lvl < 0) begin
				level_q <= 8'd0;
			end else if (lvl > 18'sd255) begin
				level_q <= 8'd255;
			end else begin
				level_q <= lvl[7:0];
			end
			pm_q        <= pm[20:16];
			phase_new_q <= phase_new;
			toggle_q    <= phase_new[16] ^ phase_q[16];
			if (slow_q == SLOW_LAST) begin
				acc_new_q  <= acc_sum[15:0];
				wave_new_q <= acc_sum[16] ? wave_next : wave_q;
			end else begin
				acc_new_q  <= acc_q;
				wave_new_q <= wave_q;
			end
		end
	end

	// pick the sample byte: wave data, fresh noise or held noise
	always_comb begin
		if (!vol_q[7]) begin
			sample_data = mem_rd;
		end else if (toggle_q) begin
			sample_data = shifter_q[7:0];
		end else begin
			sample_data = noise_hold_q[cmd.voice];
		end
		o_next = $signed(sample_data) * $signed({1'b0, level_q});
	end

	// advance noise, previous outputs, tick counter and mix sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				noise_hold_q[i] <= 8'd0;
			end
			shifter_q   <= '0;
			prior_q     <= '0;
			second_q    <= '0;
			slow_q      <= '0;
			sum_l_q     <= '0;
			sum_r_q     <= '0;
			read_data_q <= '0;
		end else begin
			if (cmd.latch) begin
				sum_l_q     <= '0;
				sum_r_q     <= '0;
				read_data_q <= '0;
			end
			if (cmd.start_tick) begin
				slow_q <= slow_q + 5'd1;
			end
			if (cmd.host_cap) begin
				read_data_q <= mem_rd;
			end
			if (cmd.sample) begin
				if (vol_q[7] && toggle_q) begin
					noise_hold_q[cmd.voice] <= shifter_q[7:0];
				end
				shifter_q <= {~(shifter_q[0] ^ shifter_q[1]), shifter_q[14:1]};
			end
			if (cmd.pan_mul) begin
				second_q <= prior_q;
				prior_q  <= o_q[15:0];
			end
			if (cmd.accum) begin
				sum_l_q <= sum_l_q + 18'(prod_l_q >>> 8);
				sum_r_q <= sum_r_q + 18'(prod_r_q >>> 8);
			end
		end
	end

	// voice output and pan products
	always_ff @(posedge clk) begin
		if (cmd.sample) begin
			o_q <= o_next;
		end
		if (cmd.pan_mul) begin
			prod_l_q <= o_q * $signed({1'b0, pan_q[3:0]});
			prod_r_q <= o_q * $signed({1'b0, pan_q[7:4]});
		end
	end

	assign read_data    = read_data_q;
	assign left_sample  = sum_l_q[15:0];
	assign right_sample = sum_r_q[15:0];
endmodule
